FILE: rtl/core/gdfs_pkg.sv
// Package with shared types, codes and the greedy direction order for the grid path finder.
`timescale 1ns / 1ps

package gdfs_pkg;

  // Default grid side and field widths.
  localparam int MAX_SIDE_DEF = 32;
  localparam int FIELD_CW     = 5;
  localparam int CFG_W        = 6;
  localparam int CFG_IDX_W    = 2;
  localparam int LEN_W        = 11;
  localparam logic [CFG_W-1:0] GRID_RESET = 6'd32;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1,
    CFG_SPARE_2     = 2'd2,
    CFG_SPARE_3     = 2'd3
  } cfg_idx_t;

  // Operation codes of a request.
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_SEARCH = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Step directions.
  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  // Engine sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_SRC,
    ST_SRCCHK,
    ST_PROBE,
    ST_CHECK,
    ST_POP,
    ST_POPLD,
    ST_RDWAIT,
    ST_DONE,
    ST_INIT
  } state_t;

  typedef struct packed {
    logic [1:0]          operation;
    logic [FIELD_CW-1:0] cell_x;
    logic [FIELD_CW-1:0] cell_y;
    logic                passable;
    logic [FIELD_CW-1:0] dest_x;
    logic [FIELD_CW-1:0] dest_y;
    logic [9:0]          path_index;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic [LEN_W-1:0]    path_length;
    logic [FIELD_CW-1:0] node_x;
    logic [FIELD_CW-1:0] node_y;
  } out_item_t;

  // Greedy neighbor order: the major axis toward the target first, away from it last.
  function automatic dir_t pick_dir(input logic x_major, input logic x_gt,
                                    input logic y_gt, input logic [1:0] slot);
    dir_t d;
    if (x_major) begin
      case (slot)
        2'd0:    d = x_gt ? DIR_LEFT : DIR_RIGHT;
        2'd1:    d = y_gt ? DIR_UP : DIR_DOWN;
        2'd2:    d = y_gt ? DIR_DOWN : DIR_UP;
        default: d = x_gt ? DIR_RIGHT : DIR_LEFT;
      endcase
    end else begin
      case (slot)
        2'd0:    d = y_gt ? DIR_UP : DIR_DOWN;
        2'd1:    d = x_gt ? DIR_LEFT : DIR_RIGHT;
        2'd2:    d = x_gt ? DIR_RIGHT : DIR_LEFT;
        default: d = y_gt ? DIR_DOWN : DIR_UP;
      endcase
    end
    return d;
  endfunction

endpackage

FILE: rtl/core/gdfs_chan_if.sv
// Valid/ready channel interface carrying one payload of a given type.
`timescale 1ns / 1ps

interface gdfs_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/gdfs_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module gdfs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/gdfs_engine.sv
// Search engine: map and stack memories with the sequencer that walks them.
`timescale 1ns / 1ps

module gdfs_engine
  import gdfs_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF,
  localparam int CW = ($clog2(MAX_SIDE) > FIELD_CW) ? $clog2(MAX_SIDE) : FIELD_CW,
  localparam int WW = CW + 1
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      req_valid,
  input  in_item_t  req,
  output logic      req_ready,
  output logic      res_valid,
  output out_item_t res,
  input  logic      res_ready,
  input  logic [WW-1:0] grid_w,
  input  logic [WW-1:0] grid_h
);

  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int DW    = $clog2(CELLS + 1);
  localparam int SEW   = 2 * CW + 3;
  localparam int MW    = AW + CW + 1;

  // Cell address is column times side plus row.
  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
    logic [MW-1:0] t;
    t = MW'(x) * MW'(MAX_SIDE) + MW'(y);
    return t[AW-1:0];
  endfunction

  state_t         state_r, state_nxt;
  in_item_t       req_r, req_nxt;
  logic [WW-1:0]  w_r, w_nxt, h_r, h_nxt;
  logic [CW-1:0]  cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [2:0]     slot_r, slot_nxt;
  logic [DW-1:0]  depth_r, depth_nxt;
  logic           found_r, found_nxt;
  logic [AW:0]    clr_r, clr_nxt;
  logic [CW-1:0]  nb_x_r, nb_x_nxt, nb_y_r, nb_y_nxt;
  logic [CW-1:0]  node_x_r, node_x_nxt, node_y_r, node_y_nxt;

  logic           map_we;
  logic [AW-1:0]  map_waddr, map_raddr;
  logic [1:0]     map_wdata, map_rdata;
  logic           stk_we;
  logic [AW-1:0]  stk_waddr, stk_raddr;
  logic [SEW-1:0] stk_wdata, stk_rdata;

  logic [CW-1:0]  src_x, src_y, dst_x, dst_y;
  logic           x_gt, y_gt, x_major, push;
  logic [CW-1:0]  adx, ady;
  dir_t           dir;

  // Map entry holds {visited, passable}.
  gdfs_ram #(.WIDTH(2), .DEPTH(CELLS)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  // Stack entry holds {x, y, next slot} of the frames below the top.
  gdfs_ram #(.WIDTH(SEW), .DEPTH(CELLS)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  assign src_x = CW'(req_r.cell_x);
  assign src_y = CW'(req_r.cell_y);
  assign dst_x = CW'(req_r.dest_x);
  assign dst_y = CW'(req_r.dest_y);

  // Greedy ordering inputs for the top cell.
  assign x_gt    = cur_x_r > dst_x;
  assign y_gt    = cur_y_r > dst_y;
  assign adx     = x_gt ? (cur_x_r - dst_x) : (dst_x - cur_x_r);
  assign ady     = y_gt ? (cur_y_r - dst_y) : (dst_y - cur_y_r);
  assign x_major = adx > ady;
  assign dir     = pick_dir(x_major, x_gt, y_gt, slot_r[1:0]);
  assign push    = map_rdata[0] && !map_rdata[1] && (depth_r != DW'(CELLS));

  // State register; after reset the map is cleared before the first request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      depth_r <= '0;
      found_r <= 1'b0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt;
      found_r <= found_nxt;
      clr_r   <= clr_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    w_r      <= w_nxt;
    h_r      <= h_nxt;
    cur_x_r  <= cur_x_nxt;
    cur_y_r  <= cur_y_nxt;
    slot_r   <= slot_nxt;
    nb_x_r   <= nb_x_nxt;
    nb_y_r   <= nb_y_nxt;
    node_x_r <= node_x_nxt;
    node_y_r <= node_y_nxt;
  end

  // Sequencer: next state, memory accesses and register updates.
  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    w_nxt      = w_r;
    h_nxt      = h_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    slot_nxt   = slot_r;
    depth_nxt  = depth_r;
    found_nxt  = found_r;
    clr_nxt    = clr_r;
    nb_x_nxt   = nb_x_r;
    nb_y_nxt   = nb_y_r;
    node_x_nxt = node_x_r;
    node_y_nxt = node_y_r;
    map_we     = 1'b0;
    map_waddr  = cell_addr(nb_x_r, nb_y_r);
    map_wdata  = 2'b11;
    map_raddr  = cell_addr(cur_x_r, cur_y_r);
    stk_we     = 1'b0;
    stk_waddr  = AW'(depth_r - 1'b1);
    stk_wdata  = {cur_x_r, cur_y_r, slot_r};
    stk_raddr  = AW'(depth_r - DW'(2));
    req_ready  = 1'b0;
    res_valid  = 1'b0;
    case (state_r)
      // Post-reset pass: every map entry becomes blocked and unvisited.
      ST_INIT: begin
        map_we    = 1'b1;
        map_waddr = clr_r[AW-1:0];
        map_wdata = 2'b00;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == (AW+1)'(CELLS - 1)) begin
          clr_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          req_nxt    = req;
          node_x_nxt = '0;
          node_y_nxt = '0;
          state_nxt  = ST_DONE;
          case (op_t'(req.operation))
            OP_WRITE: begin
              map_waddr = cell_addr(CW'(req.cell_x), CW'(req.cell_y));
              map_wdata = {1'b0, req.passable};
              map_we    = (32'(req.cell_x) < MAX_SIDE) && (32'(req.cell_y) < MAX_SIDE);
            end
            OP_SEARCH: begin
              w_nxt     = grid_w;
              h_nxt     = grid_h;
              found_nxt = 1'b0;
              depth_nxt = '0;
              clr_nxt   = '0;
              state_nxt = ST_CLR;
            end
            OP_READ: begin
              stk_raddr = AW'(req.path_index);
              if (found_r && (32'(req.path_index) < 32'(depth_r))) begin
                if (32'(req.path_index) == 32'(depth_r) - 32'd1) begin
                  node_x_nxt = cur_x_r;
                  node_y_nxt = cur_y_r;
                end else begin
                  state_nxt = ST_RDWAIT;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_RDWAIT: begin
        node_x_nxt = stk_rdata[SEW-1 -: CW];
        node_y_nxt = stk_rdata[CW+2 -: CW];
        state_nxt  = ST_DONE;
      end
      // Clearing pass: read entry i, write back entry i-1 with visited cleared.
      ST_CLR: begin
        map_raddr = clr_r[AW-1:0];
        map_waddr = AW'(clr_r - 1'b1);
        map_wdata = {1'b0, map_rdata[0]};
        map_we    = (clr_r != '0);
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == (AW+1)'(CELLS)) begin
          state_nxt = ST_SRC;
        end
      end
      ST_SRC: begin
        map_raddr = cell_addr(src_x, src_y);
        state_nxt = ST_SRCCHK;
      end
      ST_SRCCHK: begin
        if ((WW'(src_x) >= w_r) || (WW'(src_y) >= h_r) || !map_rdata[0]) begin
          state_nxt = ST_DONE;
        end else begin
          map_we    = 1'b1;
          map_waddr = cell_addr(src_x, src_y);
          map_wdata = 2'b11;
          cur_x_nxt = src_x;
          cur_y_nxt = src_y;
          slot_nxt  = '0;
          depth_nxt = DW'(1);
          if ((src_x == dst_x) && (src_y == dst_y)) begin
            found_nxt = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_PROBE;
          end
        end
      end
      // Pick the next direction of the top frame and fetch that neighbor; pop the frame when all are tried.
      ST_PROBE: begin
        if (slot_r[2]) begin
          state_nxt = ST_POP;
        end else begin
          slot_nxt = slot_r + 1'b1;
          nb_x_nxt = cur_x_r;
          nb_y_nxt = cur_y_r;
          case (dir)
            DIR_LEFT: begin
              nb_x_nxt = cur_x_r - 1'b1;
              if (cur_x_r != '0) state_nxt = ST_CHECK;
            end
            DIR_RIGHT: begin
              nb_x_nxt = cur_x_r + 1'b1;
              if ((WW'(cur_x_r) + 1'b1) < w_r) state_nxt = ST_CHECK;
            end
            DIR_UP: begin
              nb_y_nxt = cur_y_r - 1'b1;
              if (cur_y_r != '0) state_nxt = ST_CHECK;
            end
            default: begin
              nb_y_nxt = cur_y_r + 1'b1;
              if ((WW'(cur_y_r) + 1'b1) < h_r) state_nxt = ST_CHECK;
            end
          endcase
          map_raddr = cell_addr(nb_x_nxt, nb_y_nxt);
        end
      end
      // Enter the neighbor if passable, unvisited and the stack is not full; the old top goes to memory.
      ST_CHECK: begin
        state_nxt = ST_PROBE;
        if (push) begin
          map_we    = 1'b1;
          stk_we    = 1'b1;
          cur_x_nxt = nb_x_r;
          cur_y_nxt = nb_y_r;
          slot_nxt  = '0;
          depth_nxt = depth_r + 1'b1;
          if ((nb_x_r == dst_x) && (nb_y_r == dst_y)) begin
            found_nxt = 1'b1;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_POP: begin
        depth_nxt = depth_r - 1'b1;
        if (depth_r == DW'(1)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_POPLD;
        end
      end
      ST_POPLD: begin
        cur_x_nxt = stk_rdata[SEW-1 -: CW];
        cur_y_nxt = stk_rdata[CW+2 -: CW];
        slot_nxt  = stk_rdata[2:0];
        state_nxt = ST_PROBE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result fields.
  always_comb begin
    res.found       = found_r;
    res.path_length = !found_r ? '0 :
                      (32'(depth_r) > 32'd2047) ? 11'd2047 : 11'(depth_r);
    res.node_x      = FIELD_CW'(node_x_r);
    res.node_y      = FIELD_CW'(node_y_r);
  end

  // The stack never holds more frames than there are cells.
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(depth_r) <= CELLS)
    else $error("stack depth beyond cell count");

  // Entering a neighbor grows the stack by exactly one frame.
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CHECK && push) |=> depth_r == DW'($past(depth_r) + 1'b1))
    else $error("push did not grow the stack");

  // A successful search always leaves a non-empty path.
  a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && found_r) |-> depth_r != '0)
    else $error("found with empty path");

endmodule

FILE: rtl/core/grid_dfs_target_pathfinder_unit.sv
// Top level of the grid path finder: configuration registers, engine and result register.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+-----------------------------------------------
//  in_ch    | in  | valid/ready         | operation, cell, passable, dest, path_index
//  out_ch   | out | valid/ready         | found, path_length, node_x, node_y
//  cfg_*    | in  | write enable only   | grid_width (index 0), grid_height (index 1)
//
// Reset is synchronous; afterwards every map entry is cleared to blocked before the first
// request is taken. A search runs a clearing pass over the map memory, then probes
// neighbors and backtracks depth-first. One request is worked at a time.
`timescale 1ns / 1ps

module grid_dfs_target_pathfinder_unit
  import gdfs_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  gdfs_chan_if.sink            in_ch,
  gdfs_chan_if.source          out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int CW = ($clog2(MAX_SIDE) > FIELD_CW) ? $clog2(MAX_SIDE) : FIELD_CW;
  localparam int WW = CW + 1;

  logic [CFG_W-1:0] gw_r, gh_r;
  logic [WW-1:0]    grid_w, grid_h;
  logic             res_valid, res_ready;
  out_item_t        res;
  logic             out_valid_r;
  out_item_t        out_data_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= GRID_RESET;
      gh_r <= GRID_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GRID_WIDTH:  gw_r <= cfg_wdata;
        CFG_GRID_HEIGHT: gh_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Grid size in use is limited to the side of the map memory.
  assign grid_w = (32'(gw_r) > MAX_SIDE) ? WW'(MAX_SIDE) : WW'(gw_r);
  assign grid_h = (32'(gh_r) > MAX_SIDE) ? WW'(MAX_SIDE) : WW'(gh_r);

  gdfs_engine #(.MAX_SIDE(MAX_SIDE)) u_engine (
    .clk(clk), .rst_n(rst_n),
    .req_valid(in_ch.valid), .req(in_ch.data), .req_ready(in_ch.ready),
    .res_valid(res_valid), .res(res), .res_ready(res_ready),
    .grid_w(grid_w), .grid_h(grid_h)
  );

  // Output register parts the engine from the result channel.
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the grid depth-first path finder unit.
`timescale 1ns / 1ps

module tb_top;
  import gdfs_pkg::*;

  localparam int SIDE       = 32;
  localparam int CELL_COUNT = SIDE * SIDE;
  localparam int SETTLE     = 40;
  localparam int STALL_MAX  = 60000;
  localparam int HOLD_LEN   = 400;
  localparam int FILL_MAX   = 4;

  // Idle modes of the two sides.
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  gdfs_chan_if #(.T(in_item_t))  in_if ();
  gdfs_chan_if #(.T(out_item_t)) out_if ();

  grid_dfs_target_pathfinder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Clock with a 4 ns period.
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Shadow copy of the block state used to predict results.
  bit          cell_open [0:CELL_COUNT-1];
  bit          cell_seen [0:CELL_COUNT-1];
  logic [4:0]  trail_x [0:CELL_COUNT-1];
  logic [4:0]  trail_y [0:CELL_COUNT-1];
  int unsigned trail_slot [0:CELL_COUNT-1];
  int unsigned trail_depth;
  bit          route_found;
  int unsigned cols_in_use;
  int unsigned rows_in_use;

  out_item_t   pending_results [$];
  int          error_count;
  int          idle_mode;
  bit          hold_start;
  int          hold_left;
  int          quiet_cycles;

  // Step direction for the given try slot, following the greedy order.
  function automatic dir_t greedy_dir(int x, int y, int tx, int ty, int slot);
    dir_t order [4];
    int   ddx;
    int   ddy;
    ddx = (x > tx) ? x - tx : tx - x;
    ddy = (y > ty) ? y - ty : ty - y;
    if (ddx > ddy) begin
      order[0] = (x > tx) ? DIR_LEFT : DIR_RIGHT;
      order[1] = (y > ty) ? DIR_UP : DIR_DOWN;
      order[2] = (y > ty) ? DIR_DOWN : DIR_UP;
      order[3] = (x > tx) ? DIR_RIGHT : DIR_LEFT;
    end else begin
      order[0] = (y > ty) ? DIR_UP : DIR_DOWN;
      order[1] = (x > tx) ? DIR_LEFT : DIR_RIGHT;
      order[2] = (x > tx) ? DIR_RIGHT : DIR_LEFT;
      order[3] = (y > ty) ? DIR_DOWN : DIR_UP;
    end
    return order[slot];
  endfunction

  // Depth-first walk from the source; leaves the route on the trail stack.
  function automatic void walk_route(int sx, int sy, int tx, int ty);
    int   w;
    int   h;
    int   x;
    int   y;
    int   nx;
    int   ny;
    bit   ok;
    dir_t d;
    w = (cols_in_use > SIDE) ? SIDE : cols_in_use;
    h = (rows_in_use > SIDE) ? SIDE : rows_in_use;
    foreach (cell_seen[i]) cell_seen[i] = 1'b0;
    trail_depth = 0;
    route_found = 1'b0;
    if (sx >= w || sy >= h || !cell_open[sx * SIDE + sy]) return;
    cell_seen[sx * SIDE + sy] = 1'b1;
    trail_x[0] = 5'(sx);
    trail_y[0] = 5'(sy);
    trail_slot[0] = 0;
    trail_depth = 1;
    if (sx == tx && sy == ty) begin
      route_found = 1'b1;
      return;
    end
    while (trail_depth > 0) begin
      x = trail_x[trail_depth-1];
      y = trail_y[trail_depth-1];
      if (trail_slot[trail_depth-1] >= 4) begin
        trail_depth--;
        continue;
      end
      d = greedy_dir(x, y, tx, ty, trail_slot[trail_depth-1]);
      trail_slot[trail_depth-1]++;
      nx = x;
      ny = y;
      ok = 1'b0;
      case (d)
        DIR_LEFT:  if (x > 0) begin nx = x - 1; ok = 1'b1; end
        DIR_RIGHT: if (x + 1 < w) begin nx = x + 1; ok = 1'b1; end
        DIR_UP:    if (y > 0) begin ny = y - 1; ok = 1'b1; end
        default:   if (y + 1 < h) begin ny = y + 1; ok = 1'b1; end
      endcase
      if (!ok) continue;
      if (!cell_open[nx * SIDE + ny] || cell_seen[nx * SIDE + ny]) continue;
      if (trail_depth >= CELL_COUNT) continue;
      cell_seen[nx * SIDE + ny] = 1'b1;
      trail_x[trail_depth] = 5'(nx);
      trail_y[trail_depth] = 5'(ny);
      trail_slot[trail_depth] = 0;
      trail_depth++;
      if (nx == tx && ny == ty) begin
        route_found = 1'b1;
        return;
      end
    end
  endfunction

  // Expected result of one accepted request.
  function automatic out_item_t predict_result(in_item_t req);
    out_item_t r;
    r = '0;
    case (op_t'(req.operation))
      OP_WRITE:  cell_open[req.cell_x * SIDE + req.cell_y] = req.passable;
      OP_SEARCH: walk_route(req.cell_x, req.cell_y, req.dest_x, req.dest_y);
      OP_READ: begin
        if (route_found && req.path_index < trail_depth) begin
          r.node_x = trail_x[req.path_index];
          r.node_y = trail_y[req.path_index];
        end
      end
      default: ;
    endcase
    r.found = route_found;
    r.path_length = route_found ? LEN_W'((trail_depth > 2047) ? 2047 : trail_depth) : '0;
    return r;
  endfunction

  function automatic in_item_t make_req(op_t op, int cx, int cy, int pass,
                                        int tx, int ty, int idx);
    in_item_t it;
    it.operation  = op;
    it.cell_x     = 5'(cx);
    it.cell_y     = 5'(cy);
    it.passable   = 1'(pass);
    it.dest_x     = 5'(tx);
    it.dest_y     = 5'(ty);
    it.path_index = 10'(idx);
    return it;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  // Send one request; called and returning at a falling edge.
  task automatic send_request(in_item_t req);
    int pct;
    pct = (idle_mode == IDLE_SEND) ? 51 : (idle_mode == IDLE_BOTH) ? 33 : 0;
    while ($urandom_range(99) < pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.data  = req;
    do @(posedge clk); while (!in_if.ready);
    pending_results.insert(pending_results.size(), predict_result(req));
    @(negedge clk);
  endtask

  // Stop offering and wait until every result has arrived.
  task automatic drain_results();
    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, int value);
    drain_results();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = CFG_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_GRID_WIDTH) cols_in_use = value;
    if (idx == CFG_GRID_HEIGHT) rows_in_use = value;
  endtask

  // Write every cell of a w by h corner; pct is the chance a cell is open.
  task automatic fill_map(int w, int h, int pct);
    for (int x = 0; x < w; x++)
      for (int y = 0; y < h; y++)
        send_request(make_req(OP_WRITE, x, y, $urandom_range(99) < pct,
                              $urandom_range(31), $urandom_range(31), $urandom_range(1023)));
  endtask

  // Random request mix weighted toward path reads, then cell writes and searches.
  task automatic random_request(int w, int h);
    int pick;
    int idx;
    pick = $urandom_range(99);
    if (pick < 30) begin
      send_request(make_req(OP_WRITE, $urandom_range(w - 1), $urandom_range(h - 1),
                            $urandom_range(99) < 75, $urandom_range(31),
                            $urandom_range(31), $urandom_range(1023)));
    end else if (pick < 55) begin
      send_request(make_req(OP_SEARCH,
                            ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(w - 1),
                            ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(h - 1),
                            $urandom_range(1),
                            ($urandom_range(7) == 0) ? $urandom_range(31) : $urandom_range(w - 1),
                            ($urandom_range(7) == 0) ? $urandom_range(31) : $urandom_range(h - 1),
                            $urandom_range(1023)));
    end else if (pick < 95) begin
      if (trail_depth > 0 && $urandom_range(9) < 8) idx = $urandom_range(trail_depth - 1);
      else idx = $urandom_range(1023);
      send_request(make_req(OP_READ, $urandom_range(31), $urandom_range(31),
                            $urandom_range(1), $urandom_range(31), $urandom_range(31), idx));
    end else begin
      send_request(make_req(OP_NONE, $urandom_range(31), $urandom_range(31),
                            $urandom_range(1), $urandom_range(31), $urandom_range(31),
                            $urandom_range(1023)));
    end
  endtask

  // Open a corner of the map and the far corner cell, search between them, read entries back.
  task automatic test_directed();
    fill_map(3, 3, 100);
    send_request(make_req(OP_WRITE, 31, 31, 1, 0, 0, 0));
    send_request(make_req(OP_SEARCH, 0, 0, 0, 31, 31, 0));
    send_request(make_req(OP_READ, 0, 0, 0, 0, 0, 0));
    send_request(make_req(OP_READ, 31, 31, 1, 31, 31, 62));
    send_request(make_req(OP_READ, 0, 0, 0, 0, 0, 63));
    send_request(make_req(OP_READ, 0, 0, 0, 0, 0, 1023));
    send_request(make_req(OP_NONE, 31, 31, 1, 31, 31, 1023));
    // Map changes after a search keep the stored path.
    send_request(make_req(OP_WRITE, 0, 0, 0, 0, 0, 0));
    send_request(make_req(OP_READ, 0, 0, 0, 0, 0, 1));
    // Blocked source.
    send_request(make_req(OP_SEARCH, 0, 0, 1, 5, 5, 0));
    send_request(make_req(OP_READ, 0, 0, 0, 0, 0, 0));
    // Source equals destination.
    send_request(make_req(OP_SEARCH, 17, 9, 0, 17, 9, 0));
    send_request(make_req(OP_READ, 0, 0, 0, 0, 0, 0));
    // Blocked destination, searched from a source that is blocked too.
    send_request(make_req(OP_WRITE, 20, 20, 0, 0, 0, 0));
    send_request(make_req(OP_SEARCH, 10, 10, 0, 20, 20, 0));
    send_request(make_req(OP_WRITE, 20, 20, 1, 0, 0, 0));
    send_request(make_req(OP_SEARCH, 31, 0, 1, 0, 31, 5));
    send_request(make_req(OP_READ, 0, 0, 0, 0, 0, 5));
  endtask

  // Grid size extremes, including sources and destinations outside the grid.
  task automatic test_grid_sizes();
    write_register(CFG_GRID_WIDTH, 1);
    write_register(CFG_GRID_HEIGHT, 1);
    send_request(make_req(OP_SEARCH, 0, 0, 0, 0, 0, 0));
    send_request(make_req(OP_SEARCH, 0, 0, 0, 3, 0, 0));
    send_request(make_req(OP_SEARCH, 1, 0, 0, 1, 0, 0));
    write_register(CFG_GRID_HEIGHT, 32);
    send_request(make_req(OP_SEARCH, 0, 31, 0, 0, 2, 0));
    send_request(make_req(OP_READ, 0, 0, 0, 0, 0, 28));
    send_request(make_req(OP_SEARCH, 0, 0, 0, 0, 31, 0));
    write_register(CFG_GRID_WIDTH, 32);
    write_register(CFG_GRID_HEIGHT, 1);
    send_request(make_req(OP_SEARCH, 31, 0, 0, 0, 0, 0));
    send_request(make_req(OP_SEARCH, 3, 1, 0, 0, 0, 0));
  endtask

  // Random phases on small grids and on the full grid; only a corner is filled.
  task automatic test_random(int w, int h, int mode, int count);
    write_register(CFG_GRID_WIDTH, w);
    write_register(CFG_GRID_HEIGHT, h);
    fill_map((w > FILL_MAX) ? FILL_MAX : w, (h > FILL_MAX) ? FILL_MAX : h, 65);
    idle_mode = mode;
    repeat (count) random_request(w, h);
    idle_mode = IDLE_NONE;
  endtask

  // Receiver holds off while requests keep coming, then the sender waits for all.
  task automatic test_backpressure();
    hold_start = 1'b1;
    repeat (10) random_request(8, 8);
    drain_results();
  endtask

  // Receiver: random stalls by phase, and a long counted hold-off on demand.
  always @(negedge clk) begin
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready = 1'b0;
    end else if (idle_mode == IDLE_RECV) begin
      out_if.ready = $urandom_range(99) >= 51;
    end else if (idle_mode == IDLE_BOTH) begin
      out_if.ready = $urandom_range(99) >= 33;
    end else begin
      out_if.ready = 1'b1;
    end
  end

  // Result checker and stall watchdog.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_if.data.found !== want.found)
          report_mismatch("found", out_if.data.found, want.found);
        if (out_if.data.path_length !== want.path_length)
          report_mismatch("path_length", out_if.data.path_length, want.path_length);
        if (out_if.data.node_x !== want.node_x)
          report_mismatch("node_x", out_if.data.node_x, want.node_x);
        if (out_if.data.node_y !== want.node_y)
          report_mismatch("node_y", out_if.data.node_y, want.node_y);
      end
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_MAX) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_GRID_WIDTH;
    cfg_wdata    = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    hold_start   = 1'b0;
    hold_left    = 0;
    quiet_cycles = 0;
    error_count  = 0;
    idle_mode    = IDLE_NONE;
    cols_in_use  = 32;
    rows_in_use  = 32;
    trail_depth  = 0;
    route_found  = 1'b0;
    foreach (cell_open[i]) cell_open[i] = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_grid_sizes();
    test_random(4, 4, IDLE_NONE, 10);
    test_random(3, 3, IDLE_SEND, 10);
    test_random(4, 4, IDLE_RECV, 10);
    test_random(32, 32, IDLE_BOTH, 10);
    test_backpressure();
    drain_results();

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/gdfs_pkg.sv
rtl/core/gdfs_chan_if.sv
rtl/core/gdfs_ram.sv
rtl/core/gdfs_engine.sv
rtl/core/grid_dfs_target_pathfinder_unit.sv
tb/tb_top.sv
